>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bba_pkg.sv
// Types and codes shared by the buddy block allocator modules.
`default_nettype none
package bba_pkg;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } bba_kind_type;

   typedef enum logic [1:0] {
      STS_GRANTED = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_INVALID = 2'd2,
      STS_FREED   = 2'd3
   } bba_status_type;

   typedef struct packed {
      logic       req_type;
      logic [8:0] pages_wanted;
      logic [7:0] free_start;
      logic [3:0] free_order;
   } bba_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] grant_start;
      logic [3:0] grant_order;
   } bba_rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SRD,
      S_SCHK,
      S_SPLIT,
      S_MRD,
      S_MCHK
   } bba_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_READ_SCAN,
      OP_NEXT_SCAN,
      OP_TAKE,
      OP_SPLIT,
      OP_READ_BUDDY,
      OP_MERGE,
      OP_MARK,
      OP_RESP
   } bba_op_type;

   typedef struct packed {
      bba_op_type     op;
      bba_status_type status;
   } bba_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic zero;
      logic too_big;
      logic bad_order;
      logic bit_free;
      logic at_top;
      logic at_target;
   } bba_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/bba_dp.sv
// Datapath: heap-indexed free map memory, walk registers and result register.
`default_nettype none
module bba_dp #(
   parameter int TOP = 8,
   parameter int AW  = TOP + 1,
   parameter int KW  = $clog2(TOP + 1)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  bba_pkg::bba_req_type req_data,
   input  bba_pkg::bba_cmd_type cmd,
   output bba_pkg::bba_stat_type stat,
   output logic                 rsp_strobe,
   output bba_pkg::bba_rsp_type rsp_data
);
   import bba_pkg::*;

   localparam int POOL = 1 << TOP;
   localparam int DEPTH = 1 << AW;

   logic mem [DEPTH];
   logic rd_ff;

   logic          we_c;
   logic [AW-1:0] waddr_c;
   logic          wdata_c;
   logic [AW-1:0] raddr_c;

   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] n_ff, n_in;
   logic [AW-1:0] base_ff, base_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] o_ff, o_in;
   logic          free_ff, free_in;
   logic          zero_ff, zero_in;
   logic          big_ff, big_in;
   logic          bad_ff, bad_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   bba_rsp_type   rsp_data_ff, rsp_data_in;

   logic [KW-1:0] ord_c;
   logic [AW-1:0] s_c;
   logic [AW-1:0] off_c;
   logic [31:0]   start_c;
   logic [31:0]   order_c;

   // ceiling log2 of the page count, capped at the top order
   always_comb begin
      ord_c = KW'(TOP);
      for (int j = TOP; j >= 0; j--) begin
         if ((32'd1 << j) >= 32'(req_data.pages_wanted)) ord_c = KW'(j);
      end
   end

   assign s_c     = AW'(req_data.free_start) & AW'(POOL - 1);
   assign off_c   = n_ff - base_ff;
   assign start_c = 32'(off_c) << k_ff;
   assign order_c = 32'(k_ff);

   always_comb begin
      clr_in        = clr_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      o_in          = o_ff;
      free_in       = free_ff;
      zero_in       = zero_ff;
      big_in        = big_ff;
      bad_in        = bad_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      we_c          = 1'b0;
      waddr_c       = n_ff;
      wdata_c       = 1'b0;
      raddr_c       = n_ff;
      case (cmd.op)
         OP_CLEAR: begin
            we_c    = 1'b1;
            waddr_c = clr_ff;
            wdata_c = (clr_ff == AW'(1));
            clr_in  = clr_ff + AW'(1);
         end
         OP_LOAD: begin
            free_in = req_data.req_type;
            zero_in = (req_data.pages_wanted == 9'd0);
            big_in  = (18'(req_data.pages_wanted) > 18'(POOL));
            bad_in  = (32'(req_data.free_order) > 32'(TOP));
            if (req_data.req_type == REQ_FREE) begin
               k_in    = KW'(req_data.free_order);
               base_in = AW'(1) << (KW'(TOP) - KW'(req_data.free_order));
               n_in    = (AW'(1) << (KW'(TOP) - KW'(req_data.free_order)))
                         + (s_c >> req_data.free_order);
            end else begin
               k_in    = ord_c;
               o_in    = ord_c;
               base_in = AW'(1) << (KW'(TOP) - ord_c);
               n_in    = AW'(1) << (KW'(TOP) - ord_c);
            end
         end
         OP_READ_SCAN: raddr_c = n_ff;
         OP_READ_BUDDY: raddr_c = n_ff ^ AW'(1);
         OP_NEXT_SCAN: begin
            if (n_ff == ((base_ff << 1) - AW'(1))) begin
               k_in    = k_ff + KW'(1);
               base_in = base_ff >> 1;
               n_in    = base_ff >> 1;
            end else begin
               n_in = n_ff + AW'(1);
            end
         end
         OP_TAKE: begin
            we_c    = 1'b1;
            waddr_c = n_ff;
            wdata_c = 1'b0;
         end
         OP_SPLIT: begin
            // lower half carries on, upper half goes free
            we_c    = 1'b1;
            waddr_c = (n_ff << 1) | AW'(1);
            wdata_c = 1'b1;
            n_in    = n_ff << 1;
            base_in = base_ff << 1;
            k_in    = k_ff - KW'(1);
         end
         OP_MERGE: begin
            we_c    = 1'b1;
            waddr_c = n_ff ^ AW'(1);
            wdata_c = 1'b0;
            n_in    = n_ff >> 1;
            base_in = base_ff >> 1;
            k_in    = k_ff + KW'(1);
         end
         OP_MARK: begin
            we_c          = 1'b1;
            waddr_c       = n_ff;
            wdata_c       = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_data_in.status      = STS_FREED;
            rsp_data_in.grant_start = start_c[7:0];
            rsp_data_in.grant_order = order_c[3:0];
         end
         OP_RESP: begin
            rsp_strobe_in      = 1'b1;
            rsp_data_in.status = cmd.status;
            if (cmd.status == STS_GRANTED) begin
               rsp_data_in.grant_start = start_c[7:0];
               rsp_data_in.grant_order = order_c[3:0];
            end else begin
               rsp_data_in.grant_start = 8'd0;
               rsp_data_in.grant_order = 4'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_c) mem[waddr_c] <= wdata_c;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      n_ff        <= n_in;
      base_ff     <= base_in;
      k_ff        <= k_in;
      o_ff        <= o_in;
      free_ff     <= free_in;
      zero_ff     <= zero_in;
      big_ff      <= big_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.clear_last = (clr_ff == {AW{1'b1}});
   assign stat.is_free    = free_ff;
   assign stat.zero       = zero_ff;
   assign stat.too_big    = big_ff;
   assign stat.bad_order  = bad_ff;
   assign stat.bit_free   = rd_ff;
   assign stat.at_top     = (k_ff == KW'(TOP));
   assign stat.at_target  = (k_ff == o_ff);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/bba_ctrl.sv
// Controller: state machine sequencing clear, search, split and merge.
`default_nettype none
module bba_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  bba_pkg::bba_stat_type stat,
   output bba_pkg::bba_cmd_type  cmd,
   output logic                  busy
);
   import bba_pkg::*;

   bba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.status = STS_GRANTED;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_free) begin
               if (stat.bad_order) begin
                  cmd.op     = OP_RESP;
                  cmd.status = STS_INVALID;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_MRD;
               end
            end else if (stat.zero) begin
               cmd.op     = OP_RESP;
               cmd.status = STS_INVALID;
               state_in   = S_IDLE;
            end else if (stat.too_big) begin
               cmd.op     = OP_RESP;
               cmd.status = STS_NO_FREE;
               state_in   = S_IDLE;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            cmd.op   = OP_READ_SCAN;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (stat.bit_free) begin
               cmd.op   = OP_TAKE;
               state_in = S_SPLIT;
            end else if (stat.at_top) begin
               cmd.op     = OP_RESP;
               cmd.status = STS_NO_FREE;
               state_in   = S_IDLE;
            end else begin
               cmd.op   = OP_NEXT_SCAN;
               state_in = S_SRD;
            end
         end
         S_SPLIT: begin
            if (stat.at_target) begin
               cmd.op     = OP_RESP;
               cmd.status = STS_GRANTED;
               state_in   = S_IDLE;
            end else begin
               cmd.op = OP_SPLIT;
            end
         end
         S_MRD: begin
            if (stat.at_top) begin
               cmd.op   = OP_MARK;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_READ_BUDDY;
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (stat.bit_free) begin
               cmd.op   = OP_MERGE;
               state_in = S_MRD;
            end else begin
               cmd.op   = OP_MARK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/buddy_block_allocator.sv
// A reject answers from the decide state; a free merges with each free buddy up toward the
// top, then marks its node; an allocate probes free-map bits from the wanted order upward,
// takes and splits the first free node; one request is in flight at a time.
// Each result shows for one cycle on rsp_strobe; the receiver cannot stall.
// After reset a clearing pass writes all 2*POOL map entries, one a cycle, with busy high.
// POOL is the largest power of two not above TOTAL_BLOCKS.
`default_nettype none
module buddy_block_allocator #(
   parameter int TOTAL_BLOCKS = 256
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  bba_pkg::bba_req_type req_data,
   output logic                 rsp_strobe,
   output bba_pkg::bba_rsp_type rsp_data
);
   import bba_pkg::*;

   // top order of the pool: floor log2 of the block count
   localparam int TOP = $clog2(TOTAL_BLOCKS + 1) - 1;
   // free-map node index: heap layout, node 1 is the whole pool
   localparam int AW  = TOP + 1;
   localparam int KW  = $clog2(TOP + 1);

   bba_cmd_type  cmd;
   bba_stat_type stat;

   // sequencer: one request at a time, busy outside idle
   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // map memory, walk registers, result transfer register
   bba_dp #(
      .TOP (TOP),
      .AW  (AW),
      .KW  (KW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/core/bba_checker.sv
// Port-level checker for the buddy block allocator, with its bind.
`default_nettype none
`include "assert_macros.svh"
module bba_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input wire                  rsp_strobe,
   input bba_pkg::bba_rsp_type rsp_data
);
   import bba_pkg::*;

   `BBA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `BBA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy, "result while busy")
   `BBA_ASSERT_NXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "back to back results")
   `BBA_ASSERT_IMP(a_fail_zero, clock, reset,
      rsp_strobe && (rsp_data.status == STS_INVALID || rsp_data.status == STS_NO_FREE),
      rsp_data.grant_start == 8'd0 && rsp_data.grant_order == 4'd0, "failure not zeroed")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
